@@ sv/mcpp_pkg.sv @@
package mcpp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_NUM_CHANNELS  = 3'd0;
    localparam logic [2:0] CFG_PAN_SOURCE    = 3'd1;
    localparam logic [2:0] CFG_SPREAD_SOURCE = 3'd2;
    localparam logic [2:0] CFG_PAN_CONST     = 3'd3;
    localparam logic [2:0] CFG_SPREAD_CONST  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;
    localparam int CH_W     = 3;

    // fixed-point constants
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [30:0] SIN_A      = 31'd1686629713;
    localparam logic [29:0] SIN_B      = 30'd693598668;
    localparam logic [26:0] SIN_C      = 27'd80710779;
    localparam logic [20:0] EXP_BASE   = 21'd1317274;

    // fields that travel alongside each channel transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            ch;
        logic                       last;
        logic                       stereo;
    } t_side;

    // integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // root table: entry k is 2^30 * 2^(-2^-k)
    function automatic logic [30:0] root_tab(input int k);
        logic [63:0] t;
        t = isqrt64(64'd1 << 59);
        for (int i = 1; i < k; i++) t = isqrt64(t << 30);
        return t[30:0];
    endfunction

endpackage

@@ sv/mcpp_in_if.sv @@
interface mcpp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mcpp_pkg::SAMPLE_W-1:0] in_sample;
    logic [mcpp_pkg::POS_W-1:0]          pan_sample;
    logic [mcpp_pkg::POS_W-1:0]          spread_sample;

    modport source(output valid, in_sample, pan_sample, spread_sample, input ready);
    modport sink(input valid, in_sample, pan_sample, spread_sample, output ready);
endinterface

@@ sv/mcpp_out_if.sv @@
interface mcpp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mcpp_pkg::SAMPLE_W-1:0] out_sample;
    logic [mcpp_pkg::CH_W-1:0]           channel;
    logic                                last;

    modport source(output valid, out_sample, channel, last, input ready);
    modport sink(input valid, out_sample, channel, last, output ready);
endinterface

@@ sv/mcpp_isqrt.sv @@
module mcpp_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_op,
    output logic [16:0] o_root
);
    // floor(sqrt(op * 2^16)), two radicand bits per step, four steps per stage and a single step in the last stage
    localparam int STEPS = 17;

    logic [20:0] a_rem  [0:STEPS];
    logic [16:0] a_root [0:STEPS];
    logic [33:0] a_x    [0:STEPS];

    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_x[0]    = {1'b0, i_op, 16'd0};

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [20:0] w_sh;
        logic [20:0] w_trial;
        logic        w_ge;
        logic [20:0] w_rem;
        logic [16:0] w_root;

        always_comb begin
            w_sh    = {a_rem[i][18:0], a_x[i][33:32]};
            w_trial = {2'b00, a_root[i], 2'b01};
            w_ge    = w_sh >= w_trial;
            w_rem   = w_ge ? (w_sh - w_trial) : w_sh;
            w_root  = {a_root[i][15:0], w_ge};
        end

        if ((i % 4) == 3 || i == STEPS - 1) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    a_rem[i+1]  <= w_rem;
                    a_root[i+1] <= w_root;
                    a_x[i+1]    <= {a_x[i][31:0], 2'b00};
                end
            end
        end else begin : g_comb
            assign a_rem[i+1]  = w_rem;
            assign a_root[i+1] = w_root;
            assign a_x[i+1]    = {a_x[i][31:0], 2'b00};
        end
    end

    assign o_root = a_root[STEPS];
endmodule

@@ sv/multichannel_power_panner_core.sv @@
// Pans one mono Q1.15 sample over num_channels outputs and emits one result
// transaction per channel, channel 0 first, last set on the final channel. A
// sample holds the input until its last output channel is issued (two channels
// for the stereo law), since the channel sequencer issues one channel per
// cycle, unless the output stalls, into a 43-stage pipeline (square root, sine
// polynomial, 16 log2 squarings, exponent multiply, 16 root-table multiplies,
// output scaling). A stalled output freezes the whole pipeline and loses nothing.
module multichannel_power_panner_core #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mcpp_in_if.sink                        i_in,
    mcpp_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [mcpp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mcpp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
    localparam int J_W   = $clog2(MAX_CHANNELS);
    localparam int LAST  = 42;

    // configuration registers
    logic [3:0]  r_num_ch;
    logic        r_pan_src;
    logic        r_spr_src;
    logic [16:0] r_pan_const;
    logic [16:0] r_spr_const;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch    <= 4'd2;
            r_pan_src   <= 1'b0;
            r_spr_src   <= 1'b0;
            r_pan_const <= 17'd32768;
            r_spr_const <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcpp_pkg::CFG_NUM_CHANNELS:  r_num_ch    <= i_cfg_data[3:0];
                mcpp_pkg::CFG_PAN_SOURCE:    r_pan_src   <= i_cfg_data[0];
                mcpp_pkg::CFG_SPREAD_SOURCE: r_spr_src   <= i_cfg_data[0];
                mcpp_pkg::CFG_PAN_CONST:     r_pan_const <= i_cfg_data;
                mcpp_pkg::CFG_SPREAD_CONST:  r_spr_const <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-count phase step and remainder of 2^32 / N
    logic [31:0]      w_step [0:MAX_CHANNELS];
    logic [NCH_W-1:0] w_rmod [0:MAX_CHANNELS];
    for (genvar g = 0; g <= MAX_CHANNELS; g++) begin : g_tab
        if (g < 2) begin : g_lo
            assign w_step[g] = '0;
            assign w_rmod[g] = '0;
        end else begin : g_hi
            localparam logic [31:0]      STEP = 32'((64'd1 << 32) / g);
            localparam logic [NCH_W-1:0] RMOD = NCH_W'((64'd1 << 32) % g);
            assign w_step[g] = STEP;
            assign w_rmod[g] = RMOD;
        end
    end

    // global pipeline enable
    logic w_en;
    logic r_v [0:LAST];
    assign w_en = !r_v[LAST] || o_out.ready;

    // channel sequencer
    logic                        r_busy;
    logic signed [15:0]          r_sample;
    logic [16:0]                 r_pan;
    logic [16:0]                 r_spr;
    logic [NCH_W-1:0]            r_nch;
    logic                        r_stereo;
    logic [J_W-1:0]              r_j;
    logic [31:0]                 r_acc;
    logic [NCH_W:0]              r_rem;
    logic [31:0]                 r_step;
    logic [NCH_W-1:0]            r_rmod;

    logic [NCH_W-1:0] w_nch;
    logic             w_last_job;
    logic             w_accept;
    logic [NCH_W:0]   w_rem_sum;

    always_comb begin
        int n;
        n = int'(r_num_ch);
        if (n < 2) n = 2;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        w_nch = NCH_W'(n);
    end

    assign w_last_job = NCH_W'(r_j) == r_nch - 1'b1;
    assign i_in.ready = !r_busy || (w_en && w_last_job);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_rem_sum  = r_rem + {1'b0, r_rmod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_en && r_busy && w_last_job) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.in_sample;
            r_pan    <= r_pan_src ? i_in.pan_sample : r_pan_const;
            r_spr    <= r_spr_src ? i_in.spread_sample : r_spr_const;
            r_nch    <= w_nch;
            r_stereo <= w_nch == NCH_W'(2);
            r_j      <= '0;
            r_acc    <= '0;
            r_rem    <= '0;
            r_step   <= w_step[w_nch];
            r_rmod   <= w_rmod[w_nch];
        end else if (w_en && r_busy) begin
            r_j <= r_j + 1'b1;
            if (w_rem_sum >= {1'b0, r_nch}) begin
                r_rem <= w_rem_sum - {1'b0, r_nch};
                r_acc <= r_acc + r_step + 32'd1;
            end else begin
                r_rem <= w_rem_sum;
                r_acc <= r_acc + r_step;
            end
        end
    end

    // stage 0: channel transaction
    mcpp_pkg::t_side r_side [0:LAST];
    logic [31:0]     r0_th;
    logic [16:0]     r0_op;
    logic [16:0]     w_pcl;
    logic [16:0]     w_scl;

    assign w_pcl = (r_pan > mcpp_pkg::ONE_Q16) ? mcpp_pkg::ONE_Q16 : r_pan;
    assign w_scl = (r_spr > mcpp_pkg::ONE_Q16) ? mcpp_pkg::ONE_Q16 : r_spr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].sample <= r_sample;
            r_side[0].ch     <= 3'(r_j);
            r_side[0].last   <= w_last_job;
            r_side[0].stereo <= r_stereo;
            r0_th            <= {r_pan[15:0], 16'd0} - r_acc;
            if (r_stereo) begin
                r0_op <= (r_j == '0) ? (mcpp_pkg::ONE_Q16 - w_pcl) : w_pcl;
            end else begin
                r0_op <= w_scl;
            end
        end
    end

    // valid and side fields travel down the pipeline
    for (genvar k = 1; k <= LAST; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= r_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) r_side[k] <= r_side[k-1];
        end
    end

    // square root, aligned with stage 5
    logic [16:0] w_sq;
    mcpp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_op   (r0_op),
        .o_root (w_sq)
    );

    // stages 1 to 5: sine polynomial
    logic [32:0] w_d;
    logic [31:0] w_xd;
    logic [30:0] r1_x, r2_x, r3_x, r4_x;
    logic [30:0] r2_x2, r3_x2;
    logic [29:0] r3_t1;
    logic [30:0] r4_t2;
    logic [30:0] r5_s;
    logic [61:0] w_p2;
    logic [57:0] w_p3;
    logic [60:0] w_p4;
    logic [61:0] w_p5;
    logic [31:0] w_s5;

    assign w_d  = r0_th[31] ? (33'h1_0000_0000 - {1'b0, r0_th}) : {1'b0, r0_th};
    assign w_xd = 32'(33'h0_8000_0000 - w_d);
    assign w_p2 = r1_x * r1_x;
    assign w_p3 = r2_x2 * mcpp_pkg::SIN_C;
    assign w_p4 = r3_x2 * r3_t1;
    assign w_p5 = r4_x * r4_t2;
    assign w_s5 = w_p5[61:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= w_xd[31:1];
            r2_x  <= r1_x;
            r2_x2 <= w_p2[60:30];
            r3_x  <= r2_x;
            r3_x2 <= r2_x2;
            r3_t1 <= mcpp_pkg::SIN_B - w_p3[57:30];
            r4_x  <= r3_x;
            r4_t2 <= mcpp_pkg::SIN_A - w_p4[60:30];
            r5_s  <= (w_s5 > {1'b0, mcpp_pkg::ONE_Q30}) ? mcpp_pkg::ONE_Q30 : w_s5[30:0];
        end
    end

    // stage 6: cosine base, exponent and stereo gain
    logic [30:0] r6_c;
    logic [20:0] r6_e;
    logic [30:0] r6_sg;
    logic [61:0] w_p6;
    logic [21:0] w_e20;

    assign w_p6  = r5_s * r5_s;
    assign w_e20 = 22'(w_sq) * 22'd20;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_c  <= w_p6[60:30];
            r6_e  <= mcpp_pkg::EXP_BASE - w_e20[20:0];
            r6_sg <= {w_sq[16:0], 14'd0};
        end
    end

    // stage 7: normalize into [2^30, 2^31)
    typedef struct packed {
        logic [20:0] e;
        logic [30:0] sg;
        logic [4:0]  k;
        logic        z;
    } t_lcarry;

    logic [30:0] r_m  [0:16];
    logic [15:0] r_f  [0:16];
    t_lcarry     r_lc [0:16];

    always_ff @(posedge i_clk) begin
        logic [30:0] m;
        logic [4:0]  k;
        m = r6_c;
        k = '0;
        if (m[30:15] == '0) begin m = {m[14:0], 16'd0}; k = k + 5'd16; end
        if (m[30:23] == '0) begin m = {m[22:0], 8'd0};  k = k + 5'd8;  end
        if (m[30:27] == '0) begin m = {m[26:0], 4'd0};  k = k + 5'd4;  end
        if (m[30:29] == '0) begin m = {m[28:0], 2'd0};  k = k + 5'd2;  end
        if (m[30] == 1'b0)  begin m = {m[29:0], 1'b0};  k = k + 5'd1;  end
        if (w_en) begin
            r_m[0]     <= m;
            r_f[0]     <= '0;
            r_lc[0].e  <= r6_e;
            r_lc[0].sg <= r6_sg;
            r_lc[0].k  <= k;
            r_lc[0].z  <= r6_c == '0;
        end
    end

    // stages 8 to 23: one log2 fraction bit per squaring
    for (genvar g = 0; g < 16; g++) begin : g_log
        logic [61:0] w_mm;
        logic        w_b;
        assign w_mm = r_m[g] * r_m[g];
        assign w_b  = w_mm[61];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m[g+1]  <= w_b ? w_mm[61:31] : w_mm[60:30];
                r_f[g+1]  <= {r_f[g][14:0], w_b};
                r_lc[g+1] <= r_lc[g];
            end
        end
    end

    // stage 24: exponent times -log2
    logic [25:0] r24_q;
    logic [30:0] r24_sg;
    logic        r24_z;
    logic [20:0] w_n;
    logic [41:0] w_en_prod;
    logic [41:0] w_qsum;

    assign w_n       = {r_lc[16].k, 16'd0} - {5'd0, r_f[16]};
    assign w_en_prod = r_lc[16].e * w_n;
    assign w_qsum    = w_en_prod + 42'd32768;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r24_q  <= w_qsum[41:16];
            r24_sg <= r_lc[16].sg;
            r24_z  <= r_lc[16].z;
        end
    end

    // stages 25 to 40: 2^-fraction by the root table
    typedef struct packed {
        logic [15:0] fr;
        logic [4:0]  ip;
        logic [30:0] sg;
        logic        z;
    } t_rcarry;

    logic [30:0] r_r  [0:16];
    t_rcarry     r_rc [0:16];

    assign r_r[0]     = mcpp_pkg::ONE_Q30;
    assign r_rc[0].fr = r24_q[15:0];
    assign r_rc[0].ip = r24_q[20:16];
    assign r_rc[0].sg = r24_sg;
    assign r_rc[0].z  = r24_z || (r24_q[25:16] >= 10'd31);

    for (genvar g = 0; g < 16; g++) begin : g_exp
        localparam logic [30:0] TV = mcpp_pkg::root_tab(g + 1);
        logic [61:0] w_rt;
        assign w_rt = r_r[g] * TV;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_r[g+1]  <= r_rc[g].fr[15-g] ? w_rt[60:30] : r_r[g];
                r_rc[g+1] <= r_rc[g];
            end
        end
    end

    // stage 41: channel gain
    logic [30:0] r41_gain;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[40].stereo) begin
                r41_gain <= r_rc[16].sg;
            end else if (r_rc[16].z) begin
                r41_gain <= '0;
            end else begin
                r41_gain <= r_r[16] >> r_rc[16].ip;
            end
        end
    end

    // stage 42: scale and saturate into the output register
    logic signed [47:0] w_prod;
    logic signed [17:0] w_q;
    logic signed [15:0] r_out;

    assign w_prod = r_side[41].sample * $signed({1'b0, r41_gain})
                    + 48'sd536870912;
    assign w_q    = w_prod[47:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_q > 18'sd32767) begin
                r_out <= 16'sd32767;
            end else if (w_q < -18'sd32768) begin
                r_out <= -16'sd32768;
            end else begin
                r_out <= w_q[15:0];
            end
        end
    end

    assign o_out.valid      = r_v[LAST];
    assign o_out.out_sample = r_out;
    assign o_out.channel    = r_side[LAST].ch;
    assign o_out.last       = r_side[LAST].last;
endmodule
